FILE: design/ffa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, types and state codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    // Arena geometry
    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 12;

    // Field widths of the request and response transfers
    localparam int REQ_W = 12;
    localparam int TAG_W = 8;
    localparam int OUT_W = 12;

    // Header store: one entry per arena offset
    localparam int ADDR_W = $clog2(ARENA_BYTES);
    // Offsets and sizes hold the arena length and the sum of offset and size
    localparam int OFF_W  = ADDR_W + 1;
    localparam int HDR_W  = OFF_W + TAG_W;
    // Width for compares that mix sizes, offsets and request fields
    localparam int CALC_W = (OFF_W > 13) ? OFF_W + 1 : 14;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NO_SPACE = 1'b1;

    localparam logic [TAG_W-1:0] TAG_FREE = '0;

    typedef logic [OFF_W-1:0]  t_off;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        t_off              size;
        logic [TAG_W-1:0]  tag;
    } t_hdr;

    // Header store access issued by the walker
    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        t_hdr  wr_data;
    } t_mem_cmd;

    typedef struct packed {
        logic             status;
        logic [OUT_W-1:0] payload_offset;
    } t_result;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_CHK,
        S_A_SPLIT,
        S_F_CHK,
        S_C_START,
        S_C_LOAD,
        S_C_CHK,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: design/ffa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_req_if
// Request channel: allocate or free, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffa_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [ffa_pkg::REQ_W-1:0] request_bytes;
    logic [ffa_pkg::TAG_W-1:0] owner_tag;
    logic [ffa_pkg::REQ_W-1:0] release_offset;

    modport source (
        output valid, kind, request_bytes, owner_tag, release_offset,
        input  ready
    );
    modport sink (
        input  valid, kind, request_bytes, owner_tag, release_offset,
        output ready
    );
endinterface
`default_nettype wire

FILE: design/ffa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_rsp_if
// Response channel: status and payload offset, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffa_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [ffa_pkg::OUT_W-1:0] payload_offset;

    modport source (
        output valid, status, payload_offset,
        input  ready
    );
    modport sink (
        input  valid, status, payload_offset,
        output ready
    );
endinterface
`default_nettype wire

FILE: design/ffa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int AW     = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: design/ffa_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_walker
// Header chain sequencer: allocate scan, release lookup and merge pass.
// ----------------------------------------------------------------------------
module ffa_walker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ffa_req_if.sink                i_req,
    output ffa_pkg::t_mem_cmd      o_mem,
    input  wire logic [ffa_pkg::HDR_W-1:0] i_rd_data,
    output logic                   o_res_valid,
    output ffa_pkg::t_result       o_res,
    input  wire logic              i_res_ready
);
    import ffa_pkg::*;

    t_state           r_state, n_state;
    t_off             r_off, n_off;
    t_off             r_nxt, n_nxt;
    t_off             r_csize, n_csize;
    logic [TAG_W-1:0] r_ctag, n_ctag;
    logic [REQ_W-1:0] r_req, n_req;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [REQ_W-1:0] r_target, n_target;
    t_result          r_res, n_res;

    t_hdr              rd_hdr;
    logic              accept;
    logic              rel_ok;
    logic [CALC_W-1:0] c_h, c_arena, c_size, c_req;
    logic [CALC_W-1:0] walk_next, lo_off, lo_size, first_nxt, chain_nxt, merged_size;
    logic [CALC_W-1:0] poff_sum;
    logic              a_fit, a_split, walk_end, f_hit, f_cont;
    logic              first_end, chain_end, c_merge;

    assign rd_hdr  = t_hdr'(i_rd_data);
    assign accept  = i_req.valid && i_req.ready;
    assign rel_ok  = i_req.release_offset >= REQ_W'(HEADER_BYTES);

    assign c_h     = CALC_W'(HEADER_BYTES);
    assign c_arena = CALC_W'(ARENA_BYTES);
    assign c_size  = CALC_W'(rd_hdr.size);
    assign c_req   = CALC_W'(r_req);

    // allocate scan
    assign a_fit     = (rd_hdr.tag == TAG_FREE) && (c_size >= c_req);
    assign a_split   = c_size > (c_req + c_h);
    assign walk_next = CALC_W'(r_off) + c_h + c_size;
    assign walk_end  = walk_next >= c_arena;
    assign lo_off    = CALC_W'(r_off) + c_h + c_req;
    assign lo_size   = c_size - c_h - c_req;
    assign poff_sum  = CALC_W'(r_off) + c_h;

    // release lookup
    assign f_hit  = CALC_W'(r_off) == CALC_W'(r_target);
    assign f_cont = !walk_end && (walk_next <= CALC_W'(r_target));

    // merge pass: the next header always follows the one just read
    assign first_nxt   = c_h + c_size;
    assign first_end   = first_nxt >= c_arena;
    assign chain_nxt   = CALC_W'(r_nxt) + c_h + c_size;
    assign chain_end   = chain_nxt >= c_arena;
    assign c_merge     = (r_ctag == TAG_FREE) && (rd_hdr.tag == TAG_FREE);
    assign merged_size = CALC_W'(r_csize) + c_size + c_h;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_req.kind == KIND_ALLOC) begin
                        n_state = S_A_CHK;
                    end else if (rel_ok) begin
                        n_state = S_F_CHK;
                    end else begin
                        n_state = S_C_START;
                    end
                end
            end
            S_A_CHK: begin
                if (a_fit) begin
                    n_state = a_split ? S_A_SPLIT : S_DONE;
                end else if (walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_A_SPLIT: begin
                n_state = S_DONE;
            end
            S_F_CHK: begin
                if (f_hit || !f_cont) begin
                    n_state = S_C_START;
                end
            end
            S_C_START: begin
                n_state = S_C_LOAD;
            end
            S_C_LOAD: begin
                n_state = first_end ? S_DONE : S_C_CHK;
            end
            S_C_CHK: begin
                if (chain_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_off    = r_off;
        n_nxt    = r_nxt;
        n_csize  = r_csize;
        n_ctag   = r_ctag;
        n_req    = r_req;
        n_tag    = r_tag;
        n_target = r_target;
        n_res    = r_res;
        o_mem    = '0;
        i_req.ready = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_INIT: begin
                // one free block spanning the arena
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = '0;
                o_mem.wr_data = '{size: OFF_W'(ARENA_BYTES - HEADER_BYTES), tag: TAG_FREE};
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (accept) begin
                    n_req    = i_req.request_bytes;
                    n_tag    = i_req.owner_tag;
                    n_target = i_req.release_offset - REQ_W'(HEADER_BYTES);
                    n_off    = '0;
                    n_res    = '{status: ST_OK, payload_offset: '0};
                    if ((i_req.kind == KIND_ALLOC) || rel_ok) begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = '0;
                    end
                end
            end
            S_A_CHK: begin
                if (a_fit) begin
                    n_res = '{status: ST_OK, payload_offset: poff_sum[OUT_W-1:0]};
                    o_mem.wr_en = 1'b1;
                    if (a_split) begin
                        // leftover first; the granted header follows next cycle
                        o_mem.wr_addr = lo_off[ADDR_W-1:0];
                        o_mem.wr_data = '{size: lo_size[OFF_W-1:0], tag: TAG_FREE};
                    end else begin
                        o_mem.wr_addr = r_off[ADDR_W-1:0];
                        o_mem.wr_data = '{size: rd_hdr.size, tag: r_tag};
                    end
                end else begin
                    n_off = walk_next[OFF_W-1:0];
                    if (walk_end) begin
                        n_res = '{status: ST_NO_SPACE, payload_offset: '0};
                    end else begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = walk_next[ADDR_W-1:0];
                    end
                end
            end
            S_A_SPLIT: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_off[ADDR_W-1:0];
                o_mem.wr_data = '{size: c_req[OFF_W-1:0], tag: r_tag};
            end
            S_F_CHK: begin
                if (f_hit) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_off[ADDR_W-1:0];
                    o_mem.wr_data = '{size: rd_hdr.size, tag: TAG_FREE};
                end else if (f_cont) begin
                    n_off         = walk_next[OFF_W-1:0];
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = walk_next[ADDR_W-1:0];
                end
            end
            S_C_START: begin
                n_off         = '0;
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = '0;
            end
            S_C_LOAD: begin
                n_csize = rd_hdr.size;
                n_ctag  = rd_hdr.tag;
                n_nxt   = first_nxt[OFF_W-1:0];
                if (!first_end) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = first_nxt[ADDR_W-1:0];
                end
            end
            S_C_CHK: begin
                if (c_merge) begin
                    // absorb the next block into the current one
                    n_csize       = merged_size[OFF_W-1:0];
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_off[ADDR_W-1:0];
                    o_mem.wr_data = '{size: merged_size[OFF_W-1:0], tag: r_ctag};
                end else begin
                    n_off   = r_nxt;
                    n_csize = rd_hdr.size;
                    n_ctag  = rd_hdr.tag;
                end
                n_nxt = chain_nxt[OFF_W-1:0];
                if (!chain_end) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = chain_nxt[ADDR_W-1:0];
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
        r_off    <= n_off;
        r_nxt    <= n_nxt;
        r_csize  <= n_csize;
        r_ctag   <= n_ctag;
        r_req    <= n_req;
        r_tag    <= n_tag;
        r_target <= n_target;
        r_res    <= n_res;
    end

endmodule
`default_nettype wire

FILE: design/ffa_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_out_reg
// Response holding register between the walker and the response channel.
// ----------------------------------------------------------------------------
module ffa_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire ffa_pkg::t_result  i_res,
    output logic                   o_can_load,
    ffa_rsp_if.source              o_rsp
);
    import ffa_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res, n_res;

    assign o_can_load = !r_valid || o_rsp.ready;

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (i_load && o_can_load) begin
            n_valid = 1'b1;
            n_res   = i_res;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.status         = r_res.status;
    assign o_rsp.payload_offset = r_res.payload_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_res <= n_res;
    end

endmodule
`default_nettype wire

FILE: design/first_fit_heap_allocator.sv
`default_nettype none
// Sequence: an allocate reads one header per block scanned and, when the block splits, writes the
// leftover header before the granted one. A free walks the chain up to the released block, then
// makes a merge pass over the whole chain; each header visited costs one read of the header store.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset: synchronous, active low; the first state after reset writes the single free block at offset 0.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with split on allocate and merge of free neighbours
// on release, over one header store addressed by arena offset.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ffa_req_if.sink   i_req,
    ffa_rsp_if.source o_rsp
);
    import ffa_pkg::*;

    // header store access from the walker
    t_mem_cmd         mem_cmd;
    logic [HDR_W-1:0] mem_rd_data;

    // finished result towards the output register
    logic    res_valid;
    t_result res;
    logic    res_ready;

    // Header store: one entry per arena offset; only chain headers are ever read,
    // so entries other than offset 0 need no clearing.
    ffa_ram #(
        .WIDTH (HDR_W),
        .DEPTH (ARENA_BYTES)
    ) u_hdr_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_cmd.wr_en),
        .i_wr_addr (mem_cmd.wr_addr),
        .i_wr_data (mem_cmd.wr_data),
        .i_rd_en   (mem_cmd.rd_en),
        .i_rd_addr (mem_cmd.rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Sequencer: walks the chain one header a cycle, issuing the next read
    // from the header just returned; writes never hit the address read in the
    // same cycle, so no forwarding is needed.
    ffa_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_mem       (mem_cmd),
        .i_rd_data   (mem_rd_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Hold the result until the transfer completes; a new request may be
    // accepted meanwhile.
    ffa_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .o_can_load (res_ready),
        .o_rsp      (o_rsp)
    );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit heap allocator. A directed opening
// covers zero-size and full-arena requests, exact fits, splits, zero tags and
// bad or repeated releases. A long random run of allocate and release traffic
// follows, mostly well formed and with some noise. Every accepted request is
// applied to a shadow copy of the header store, and each response is compared
// with the answer that the shadow predicts.
// ----------------------------------------------------------------------------
module tb;
    import ffa_pkg::*;

    // Two shadows of the header store: one follows the plan while the
    // stimulus is built, the other follows the requests the block accepts.
    localparam int SHADOW_PLAN  = 0;
    localparam int SHADOW_CHECK = 1;

    localparam int RANDOM_ITEMS   = 1130;
    localparam int LONG_HOLD      = 3000;
    localparam int LONG_HOLD_AT   = 400;
    localparam int SETTLE_CYCLES  = 2000;
    localparam int MAX_LIVE       = 28;

    typedef struct {
        logic              kind;
        logic [REQ_W-1:0]  request_bytes;
        logic [TAG_W-1:0]  owner_tag;
        logic [REQ_W-1:0]  release_offset;
        bit                hold;          // offer only once every answer is back
    } t_req_item;

    logic i_clk;
    logic i_rst_n;

    ffa_req_if req_if ();
    ffa_rsp_if rsp_if ();

    first_fit_heap_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    t_hdr        heap_hdr [2][ARENA_BYTES];
    t_req_item   request_q [$];
    t_result     answer_q [$];
    int unsigned live_offsets [$];
    int unsigned freed_offsets [$];
    bit          hold_next;

    int unsigned mismatch_count;
    int unsigned accepted_count;

    // Sender state
    bit          req_taken;
    bit          req_offering;
    int unsigned burst_left;
    int unsigned gap_left;

    // Receiver state
    int unsigned ready_pct;
    int unsigned mode_left;
    int unsigned long_hold_left;
    bit          long_hold_done;

    // ------------------------------------------------------------------------
    // Shadow of the allocator: apply one request to shadow c, return the answer
    // ------------------------------------------------------------------------
    function automatic t_result heap_apply(input int c, input t_req_item it);
        int unsigned pos;
        int unsigned nxt;
        int unsigned lo;
        int unsigned sz;
        int unsigned req;
        int unsigned target;
        bit          found;
        t_result     r;
        r.status         = ST_OK;
        r.payload_offset = '0;
        pos   = 0;
        found = 1'b0;
        req   = 32'(it.request_bytes);
        if (it.kind == KIND_ALLOC) begin
            // First fit: walk the chain from offset zero
            while (pos < ARENA_BYTES && !found) begin
                sz = 32'(heap_hdr[c][pos].size);
                if (heap_hdr[c][pos].tag == TAG_FREE && sz >= req) begin
                    // Split only when the leftover can carry a header of its own
                    if (sz > req + HEADER_BYTES) begin
                        lo = pos + HEADER_BYTES + req;
                        heap_hdr[c][lo].size = t_off'(sz - HEADER_BYTES - req);
                        heap_hdr[c][lo].tag  = TAG_FREE;
                        heap_hdr[c][pos].size = t_off'(req);
                    end
                    heap_hdr[c][pos].tag = it.owner_tag;
                    r.payload_offset     = OUT_W'(pos + HEADER_BYTES);
                    found                = 1'b1;
                end else begin
                    pos = pos + HEADER_BYTES + sz;
                end
            end
            if (!found) begin
                r.status = ST_NO_SPACE;
            end
        end else begin
            // Release: mark the block only if its header lies on the chain
            if (32'(it.release_offset) >= HEADER_BYTES) begin
                target = 32'(it.release_offset) - HEADER_BYTES;
                while (pos < ARENA_BYTES && pos <= target && !found) begin
                    if (pos == target) begin
                        heap_hdr[c][pos].tag = TAG_FREE;
                        found = 1'b1;
                    end else begin
                        pos = pos + HEADER_BYTES + 32'(heap_hdr[c][pos].size);
                    end
                end
            end
            // Merge every run of free neighbours, whatever happened above
            pos   = 0;
            found = 1'b0;
            while (!found) begin
                nxt = pos + HEADER_BYTES + 32'(heap_hdr[c][pos].size);
                if (nxt >= ARENA_BYTES) begin
                    found = 1'b1;
                end else if (heap_hdr[c][pos].tag == TAG_FREE &&
                             heap_hdr[c][nxt].tag == TAG_FREE) begin
                    heap_hdr[c][pos].size = t_off'(32'(heap_hdr[c][pos].size) +
                                                   32'(heap_hdr[c][nxt].size) + HEADER_BYTES);
                    heap_hdr[c][nxt].size = '0;
                end else begin
                    pos = nxt;
                end
            end
        end
        return r;
    endfunction

    task automatic reset_shadow(input int c);
        for (int i = 0; i < ARENA_BYTES; i++) begin
            heap_hdr[c][i] = '0;
        end
        heap_hdr[c][0].size = t_off'(ARENA_BYTES - HEADER_BYTES);
        heap_hdr[c][0].tag  = TAG_FREE;
    endtask

    // Append a request to the pending queue and track which offsets are live
    task automatic queue_request(input t_req_item it);
        t_result r;
        int      idx;
        it.hold   = hold_next;
        hold_next = 1'b0;
        r = heap_apply(SHADOW_PLAN, it);
        if (it.kind == KIND_ALLOC) begin
            if (r.status == ST_OK && it.owner_tag != TAG_FREE) begin
                live_offsets.push_back(32'(r.payload_offset));
            end
        end else begin
            idx = -1;
            foreach (live_offsets[i]) begin
                if (live_offsets[i] == 32'(it.release_offset)) begin
                    idx = i;
                end
            end
            if (idx >= 0) begin
                live_offsets.delete(idx);
                freed_offsets.push_back(32'(it.release_offset));
                if (freed_offsets.size() > 16) begin
                    void'(freed_offsets.pop_front());
                end
            end
        end
        request_q.push_back(it);
    endtask

    // Unused fields carry random values so that all their bits toggle
    task automatic queue_alloc(input int unsigned bytes, input int unsigned tag);
        t_req_item it;
        it.kind           = KIND_ALLOC;
        it.request_bytes  = REQ_W'(bytes);
        it.owner_tag      = TAG_W'(tag);
        it.release_offset = REQ_W'($urandom_range(0, 4095));
        it.hold           = 1'b0;
        queue_request(it);
    endtask

    task automatic queue_release(input int unsigned off);
        t_req_item it;
        it.kind           = KIND_FREE;
        it.request_bytes  = REQ_W'($urandom_range(0, 4095));
        it.owner_tag      = TAG_W'($urandom_range(0, 255));
        it.release_offset = REQ_W'(off);
        it.hold           = 1'b0;
        queue_request(it);
    endtask

    function automatic int unsigned alloc_size();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 5)  return 0;
        if (p < 85) return $urandom_range(1, 96);
        if (p < 95) return $urandom_range(97, 600);
        return $urandom_range(0, 4095);
    endfunction

    function automatic int unsigned owner_tag_pick();
        if ($urandom_range(0, 99) < 5) return 0;
        return $urandom_range(1, 255);
    endfunction

    function automatic int unsigned gap_pick();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: directed opening, then random traffic
    // ------------------------------------------------------------------------
    task automatic build_stimulus();
        int unsigned p;
        int unsigned n;
        // Zero-size request, request larger than the free arena, zero tag
        queue_alloc(0, 1);
        queue_alloc(4095, 255);
        queue_alloc(100, 0);
        queue_alloc(64, 255);
        queue_alloc(200, 128);
        // Releases that do not name a block on the chain
        queue_release(0);
        queue_release(11);
        queue_release(13);
        queue_release(4095);
        // Release the first block twice
        queue_release(12);
        queue_release(12);
        while (live_offsets.size() > 0) begin
            queue_release(live_offsets[0]);
        end
        // Whole arena as one exact fit, then nothing left
        hold_next = 1'b1;
        queue_alloc(ARENA_BYTES - HEADER_BYTES, 7);
        queue_alloc(0, 9);
        queue_release(12);
        // Just over the split threshold: a one-byte block is split off
        queue_alloc(ARENA_BYTES - 2 * HEADER_BYTES - 1, 3);
        queue_release(12);
        // Further over it: a two-byte block is left behind and then taken
        queue_alloc(ARENA_BYTES - 2 * HEADER_BYTES - 1 - 1, 85);
        queue_alloc(1, 42);
        queue_alloc(0, 17);
        queue_release(12);
        queue_release(ARENA_BYTES - 1);

        hold_next = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                hold_next = 1'b1;
            end
            p = $urandom_range(0, 99);
            if (p < 12) begin
                // Noise: stray offsets, repeated releases, odd allocations
                case ($urandom_range(0, 4))
                    0: queue_release($urandom_range(0, 4095));
                    1: queue_release($urandom_range(0, HEADER_BYTES - 1));
                    2: begin
                        if (freed_offsets.size() > 0) begin
                            queue_release(freed_offsets[$urandom_range(0,
                                          freed_offsets.size() - 1)]);
                        end else begin
                            queue_release($urandom_range(0, 4095));
                        end
                    end
                    3: queue_alloc(alloc_size(), 0);
                    default: queue_alloc($urandom_range(0, 4095), owner_tag_pick());
                endcase
            end else if (live_offsets.size() == 0 ||
                         (p < 58 && live_offsets.size() < MAX_LIVE)) begin
                queue_alloc(alloc_size(), owner_tag_pick());
            end else begin
                queue_release(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver: bursts of transfers separated by random gaps
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_requests
        logic offer;
        offer = req_offering;
        // Drop the item that transferred at the last rising edge
        if (req_taken) begin
            offer     = 1'b0;
            req_taken = 1'b0;
        end
        if (!offer && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (request_q.size() > 0 &&
                         !(request_q[0].hold && answer_q.size() > 0)) begin
                offer = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = gap_pick();
                end
            end
        end
        req_offering = offer;
        req_if.valid <= offer;
        if (offer) begin
            req_if.kind           <= request_q[0].kind;
            req_if.request_bytes  <= request_q[0].request_bytes;
            req_if.owner_tag      <= request_q[0].owner_tag;
            req_if.release_offset <= request_q[0].release_offset;
        end else begin
            req_if.kind           <= 1'($urandom_range(0, 1));
            req_if.request_bytes  <= REQ_W'($urandom_range(0, 4095));
            req_if.owner_tag      <= TAG_W'($urandom_range(0, 255));
            req_if.release_offset <= REQ_W'($urandom_range(0, 4095));
        end
    end

    // ------------------------------------------------------------------------
    // Response ready: random duty cycle whose setting is redrawn at random,
    // plus one long hold-off so that the block backs up into its input
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_ready
        logic rdy;
        if (!long_hold_done && accepted_count >= LONG_HOLD_AT) begin
            long_hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
        end
        if (long_hold_left > 0) begin
            long_hold_left--;
            rdy = 1'b0;
        end else begin
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 90;
                    2: ready_pct = 50;
                    default: ready_pct = 20;
                endcase
                mode_left = $urandom_range(64, 512);
            end else begin
                mode_left--;
            end
            rdy = ($urandom_range(0, 99) < ready_pct);
        end
        rsp_if.ready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each request transfer, check each response transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_channels
        t_result   want;
        t_req_item taken;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected response, expected none, %s %0d offset %0d",
                             $time, "actual status", rsp_if.status,
                             rsp_if.payload_offset);
                    mismatch_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, rsp_if.status);
                        mismatch_count++;
                    end
                    if (rsp_if.payload_offset !== want.payload_offset) begin
                        $display("%0t: payload_offset mismatch, expected %0d actual %0d",
                                 $time, want.payload_offset, rsp_if.payload_offset);
                        mismatch_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                taken = request_q.pop_front();
                answer_q.push_back(heap_apply(SHADOW_CHECK, taken));
                req_taken = 1'b1;
                accepted_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.kind           = KIND_ALLOC;
        req_if.request_bytes  = '0;
        req_if.owner_tag      = '0;
        req_if.release_offset = '0;
        rsp_if.ready          = 1'b0;
        mismatch_count        = 0;
        accepted_count        = 0;
        req_taken             = 1'b0;
        req_offering          = 1'b0;
        burst_left            = 1;
        gap_left              = 0;
        ready_pct             = 100;
        mode_left             = 0;
        long_hold_left        = 0;
        long_hold_done        = 1'b0;
        hold_next             = 1'b0;
        reset_shadow(SHADOW_PLAN);
        reset_shadow(SHADOW_CHECK);
        build_stimulus();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Hold until every request has transferred and every answer is back
        while (request_q.size() > 0 || answer_q.size() > 0) begin
            @(posedge i_clk);
        end
        // Let a stray late response show itself
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #60000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
design/ffa_pkg.sv
design/ffa_req_if.sv
design/ffa_rsp_if.sv
design/ffa_ram.sv
design/ffa_walker.sv
design/ffa_out_reg.sv
design/first_fit_heap_allocator.sv
tb/tb.sv
